@@ rtl/vrt_pkg.sv @@
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared constants, types and helpers of the versioned record table.
// ----------------------------------------------------------------------------
package vrt_pkg;

   // table geometry
   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BYTES = 8;
   localparam int KEY_W       = KEY_BYTES * 8;
   localparam int VAL_W       = VALUE_BYTES * 8;

   // field widths
   localparam int CMD_W  = 2;
   localparam int LEN_W  = 4;
   localparam int SEQ_W  = 16;
   localparam int TIME_W = 32;
   localparam int EXP_W  = 33;
   localparam int DATA_W = 64;

   // sequence number wraparound test
   localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;
   localparam logic [SEQ_W-1:0] SEQ_MASK = 16'hFFFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_EXTEND = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   // key memory entry
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [KEY_W-1:0] key;
   } key_ent_type;

   // record memory entry
   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [VAL_W-1:0] val;
      logic [LEN_W-1:0] vlen;
      logic [EXP_W-1:0] expiry;
   } rec_type;

   // shared subtract and compare unit result
   typedef struct packed {
      logic             lt;
      logic             eq;
      logic [EXP_W-1:0] diff;
   } alu_res_type;

   // keep the first n bytes of a packed word
   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int b = 0; b < DATA_W / 8; b++) begin
         m[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // clamp a byte count to a maximum
   function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] n,
                                                 input logic [LEN_W-1:0] lim);
      return (n > lim) ? lim : n;
   endfunction

endpackage

@@ rtl/vrt_req_if.sv @@
// ----------------------------------------------------------------------------
// vrt_req_if
// Command channel of the record table: valid, ready and one command item.
// ----------------------------------------------------------------------------
interface vrt_req_if;
   import vrt_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [DATA_W-1:0]   record_key;
   logic [LEN_W-1:0]    key_length;
   logic [SEQ_W-1:0]    sequence_req;
   logic [DATA_W-1:0]   record_value;
   logic [LEN_W-1:0]    value_length;
   logic [TIME_W-1:0]   lifetime;
   logic [TIME_W-1:0]   now_seconds;

   modport source (
      output valid, command, record_key, key_length, sequence_req,
             record_value, value_length, lifetime, now_seconds,
      input  ready
   );

   modport sink (
      input  valid, command, record_key, key_length, sequence_req,
             record_value, value_length, lifetime, now_seconds,
      output ready
   );
endinterface

@@ rtl/vrt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// vrt_rsp_if
// Result channel of the record table: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface vrt_rsp_if;
   import vrt_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic                updated;
   logic                conflict;
   logic                table_full;
   logic [SEQ_W-1:0]    stored_sequence;
   logic [TIME_W-1:0]   remaining_seconds;
   logic [DATA_W-1:0]   stored_value;

   modport source (
      output valid, found, updated, conflict, table_full, stored_sequence,
             remaining_seconds, stored_value,
      input  ready
   );

   modport sink (
      input  valid, found, updated, conflict, table_full, stored_sequence,
             remaining_seconds, stored_value,
      output ready
   );
endinterface

@@ rtl/versioned_record_table.sv @@
// Steps: a scan reads and compares the keys in slot order; a match reads and loads the record,
// compares its expiry against the new expiry and then against now, applies the command and
// works out the time left (a flush skips that); an unknown key goes to the insert or miss step.
// Throughput: one command at a time, set by the key scan (one slot compare a cycle) and the
// shared expiry subtractor; a result still held in the output register delays the next one.
// Reset clears all slot valid bits at once; the block takes commands right after.
// ----------------------------------------------------------------------------
// versioned_record_table
// Keyed record table with wraparound sequence numbers and expiry times.
// ----------------------------------------------------------------------------
module versioned_record_table (
   input  logic       clock,
   input  logic       reset,
   vrt_req_if.sink    req_if,
   vrt_rsp_if.source  rsp_if
);
   import vrt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NOMATCH,
      ST_REC_RD,
      ST_LOAD,
      ST_CMP_NEW,
      ST_CMP_NOW,
      ST_APPLY,
      ST_REM,
      ST_RESP
   } state_type;

   state_type state_ff;

   // latched command
   cmd_type            cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [LEN_W-1:0]   klen_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [LEN_W-1:0]   vlen_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [EXP_W-1:0]   newexp_ff;

   // scan control
   logic [SLOT_W:0]    scan_ff;
   logic [SLOT_W-1:0]  cmp_idx_ff;
   logic               cmp_vld_ff;
   logic [SLOT_W-1:0]  match_idx_ff;
   logic               free_found_ff;
   logic [SLOT_W-1:0]  free_idx_ff;
   logic [SLOTS-1:0]   valid_ff;

   // working record
   logic [SEQ_W-1:0]   cur_seq_ff;
   logic [VAL_W-1:0]   cur_val_ff;
   logic [LEN_W-1:0]   cur_vlen_ff;
   logic [EXP_W-1:0]   cur_exp_ff;
   logic               lt_new_ff;
   logic               gt_new_ff;
   logic               lt_now_ff;
   logic [TIME_W-1:0]  rem_ff;

   // result flags
   logic               found_ff;
   logic               upd_ff;
   logic               conf_ff;
   logic               full_ff;
   logic               has_rec_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic               rsp_upd_ff;
   logic               rsp_conf_ff;
   logic               rsp_full_ff;
   logic [SEQ_W-1:0]   rsp_seq_ff;
   logic [TIME_W-1:0]  rsp_rem_ff;
   logic [DATA_W-1:0]  rsp_val_ff;

   // memory ports
   logic               key_we;
   key_ent_type        key_wdata;
   key_ent_type        key_rdata;
   logic [SLOT_W-1:0]  key_raddr;
   logic               rec_we;
   logic [SLOT_W-1:0]  rec_waddr;
   rec_type            rec_wdata;
   rec_type            rec_rdata;

   // input conditioning
   logic [LEN_W-1:0]   klen_c;
   logic [LEN_W-1:0]   vlen_c;
   logic               req_xfer;
   logic               rsp_load;

   // shared unit
   logic [EXP_W-1:0]   alu_a;
   logic [EXP_W-1:0]   alu_b;
   alu_res_type        alu_res;

   // apply step next values
   logic [SEQ_W-1:0]   seq_diff;
   logic               seq_eq;
   logic               val_eq;
   logic [SEQ_W-1:0]   nxt_seq_in;
   logic [VAL_W-1:0]   nxt_val_in;
   logic [LEN_W-1:0]   nxt_vlen_in;
   logic [EXP_W-1:0]   nxt_exp_in;
   logic               nxt_upd_in;
   logic               nxt_conf_in;

   logic               slot_hit;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_if.ready);

   assign klen_c = clip_len(req_if.key_length, LEN_W'(KEY_BYTES));
   assign vlen_c = clip_len(req_if.value_length, LEN_W'(VALUE_BYTES));

   // key and record memories
   vrt_ram #(.WIDTH($bits(key_ent_type)), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_idx_ff),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   vrt_ram #(.WIDTH($bits(rec_type)), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (match_idx_ff),
      .rd_data (rec_rdata)
   );

   assign key_raddr = scan_ff[SLOT_W-1:0];

   // slot compare on the scan pipeline
   assign slot_hit = cmp_vld_ff && valid_ff[cmp_idx_ff]
                     && (key_rdata.len == klen_ff) && (key_rdata.key == key_ff);

   // memory writes: insert into a free slot or rewrite the matched record
   always_comb begin
      key_we         = (state_ff == ST_NOMATCH) && (cmd_ff == CMD_UPDATE)
                       && free_found_ff;
      key_wdata.len  = klen_ff;
      key_wdata.key  = key_ff;
      rec_we         = key_we || ((state_ff == ST_APPLY)
                       && ((cmd_ff == CMD_UPDATE) || (cmd_ff == CMD_EXTEND)));
      if (key_we) begin
         rec_waddr        = free_idx_ff;
         rec_wdata.seq    = seq_ff;
         rec_wdata.val    = val_ff;
         rec_wdata.vlen   = vlen_ff;
         rec_wdata.expiry = newexp_ff;
      end else begin
         rec_waddr        = match_idx_ff;
         rec_wdata.seq    = nxt_seq_in;
         rec_wdata.val    = nxt_val_in;
         rec_wdata.vlen   = nxt_vlen_in;
         rec_wdata.expiry = nxt_exp_in;
      end
   end

   // shared subtractor operand select
   assign alu_a = cur_exp_ff;
   assign alu_b = (state_ff == ST_CMP_NEW) ? newexp_ff : EXP_W'(now_ff);

   vrt_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

   // update and extend rules on the loaded record
   assign seq_diff = seq_ff - cur_seq_ff;
   assign seq_eq   = (seq_ff == cur_seq_ff);
   assign val_eq   = (vlen_ff == cur_vlen_ff) && (val_ff == cur_val_ff);

   always_comb begin
      nxt_seq_in  = cur_seq_ff;
      nxt_val_in  = cur_val_ff;
      nxt_vlen_in = cur_vlen_ff;
      nxt_exp_in  = cur_exp_ff;
      nxt_upd_in  = 1'b0;
      nxt_conf_in = 1'b0;
      case (cmd_ff)
         CMD_UPDATE: begin
            if (seq_eq) begin
               if (val_eq) begin
                  // refresh: only ever later
                  if (lt_new_ff) begin
                     nxt_exp_in = newexp_ff;
                     nxt_upd_in = 1'b1;
                  end
               end else begin
                  // conflict: later expiry wins, a tie goes to the incoming record
                  nxt_conf_in = 1'b1;
                  if (!gt_new_ff) begin
                     nxt_val_in  = val_ff;
                     nxt_vlen_in = vlen_ff;
                     nxt_exp_in  = newexp_ff;
                     nxt_upd_in  = 1'b1;
                  end
               end
            end else if ((seq_diff & SEQ_HALF) == '0) begin
               // incoming number is newer
               nxt_seq_in  = seq_ff;
               nxt_val_in  = val_ff;
               nxt_vlen_in = vlen_ff;
               nxt_exp_in  = newexp_ff;
               nxt_upd_in  = 1'b1;
            end
         end
         CMD_EXTEND: begin
            if (lt_now_ff) begin
               nxt_seq_in = (cur_seq_ff + SEQ_W'(1)) & SEQ_MASK;
            end
            if (lt_new_ff) begin
               nxt_exp_in = newexp_ff;
               nxt_upd_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         // result register drains independently
         if (rsp_valid_ff && rsp_if.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  cmd_ff        <= cmd_type'(req_if.command);
                  klen_ff       <= klen_c;
                  key_ff        <= KEY_W'(req_if.record_key & byte_mask(klen_c));
                  seq_ff        <= req_if.sequence_req;
                  vlen_ff       <= vlen_c;
                  val_ff        <= VAL_W'(req_if.record_value & byte_mask(vlen_c));
                  now_ff        <= req_if.now_seconds;
                  newexp_ff     <= EXP_W'(req_if.now_seconds) + EXP_W'(req_if.lifetime);
                  scan_ff       <= '0;
                  cmp_vld_ff    <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               // issue the next key read, compare the one read last cycle
               if (scan_ff < (SLOT_W + 1)'(SLOTS)) begin
                  cmp_idx_ff <= scan_ff[SLOT_W-1:0];
                  scan_ff    <= scan_ff + (SLOT_W + 1)'(1);
               end
               if (cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cmp_idx_ff;
               end
               if (slot_hit) begin
                  match_idx_ff <= cmp_idx_ff;
                  cmp_vld_ff   <= 1'b0;
                  state_ff     <= ST_REC_RD;
               end else if (cmp_vld_ff && (cmp_idx_ff == SLOT_W'(SLOTS - 1))) begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= ST_NOMATCH;
               end else begin
                  cmp_vld_ff <= (scan_ff < (SLOT_W + 1)'(SLOTS));
               end
            end

            ST_NOMATCH: begin
               found_ff <= 1'b0;
               conf_ff  <= 1'b0;
               if ((cmd_ff == CMD_UPDATE) && free_found_ff) begin
                  // insert into the lowest free slot
                  valid_ff[free_idx_ff] <= 1'b1;
                  cur_seq_ff  <= seq_ff;
                  cur_val_ff  <= val_ff;
                  cur_vlen_ff <= vlen_ff;
                  cur_exp_ff  <= newexp_ff;
                  upd_ff      <= 1'b1;
                  full_ff     <= 1'b0;
                  has_rec_ff  <= 1'b1;
                  state_ff    <= ST_REM;
               end else begin
                  upd_ff     <= 1'b0;
                  full_ff    <= (cmd_ff == CMD_UPDATE);
                  has_rec_ff <= 1'b0;
                  state_ff   <= ST_RESP;
               end
            end

            ST_REC_RD: begin
               state_ff <= ST_LOAD;
            end

            ST_LOAD: begin
               cur_seq_ff  <= rec_rdata.seq;
               cur_val_ff  <= rec_rdata.val;
               cur_vlen_ff <= rec_rdata.vlen;
               cur_exp_ff  <= rec_rdata.expiry;
               found_ff    <= 1'b1;
               upd_ff      <= 1'b0;
               conf_ff     <= 1'b0;
               full_ff     <= 1'b0;
               state_ff    <= ST_CMP_NEW;
            end

            ST_CMP_NEW: begin
               lt_new_ff <= alu_res.lt;
               gt_new_ff <= !alu_res.lt && !alu_res.eq;
               state_ff  <= ST_CMP_NOW;
            end

            ST_CMP_NOW: begin
               lt_now_ff <= alu_res.lt;
               state_ff  <= ST_APPLY;
            end

            ST_APPLY: begin
               if (cmd_ff == CMD_FLUSH) begin
                  valid_ff[match_idx_ff] <= 1'b0;
                  has_rec_ff <= 1'b0;
                  state_ff   <= ST_RESP;
               end else begin
                  cur_seq_ff  <= nxt_seq_in;
                  cur_val_ff  <= nxt_val_in;
                  cur_vlen_ff <= nxt_vlen_in;
                  cur_exp_ff  <= nxt_exp_in;
                  upd_ff      <= nxt_upd_in;
                  conf_ff     <= nxt_conf_in;
                  has_rec_ff  <= 1'b1;
                  state_ff    <= ST_REM;
               end
            end

            ST_REM: begin
               // time left, clipped at zero and at 32 bits
               if (alu_res.lt || alu_res.eq) begin
                  rem_ff <= '0;
               end else if (alu_res.diff[EXP_W-1]) begin
                  rem_ff <= '1;
               end else begin
                  rem_ff <= alu_res.diff[TIME_W-1:0];
               end
               state_ff <= ST_RESP;
            end

            ST_RESP: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_upd_ff   <= upd_ff;
                  rsp_conf_ff  <= conf_ff;
                  rsp_full_ff  <= full_ff;
                  rsp_seq_ff   <= has_rec_ff ? cur_seq_ff : '0;
                  rsp_rem_ff   <= has_rec_ff ? rem_ff : '0;
                  rsp_val_ff   <= has_rec_ff ? DATA_W'(cur_val_ff) : '0;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result channel
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.found             = rsp_found_ff;
   assign rsp_if.updated           = rsp_upd_ff;
   assign rsp_if.conflict          = rsp_conf_ff;
   assign rsp_if.table_full        = rsp_full_ff;
   assign rsp_if.stored_sequence   = rsp_seq_ff;
   assign rsp_if.remaining_seconds = rsp_rem_ff;
   assign rsp_if.stored_value      = rsp_val_ff;

endmodule

@@ rtl/vrt_ram.sv @@
// ----------------------------------------------------------------------------
// vrt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/vrt_alu.sv @@
// ----------------------------------------------------------------------------
// vrt_alu
// Shared expiry unit: one subtractor giving the difference, less and equal.
// ----------------------------------------------------------------------------
module vrt_alu (
   input  logic [vrt_pkg::EXP_W-1:0] op_a,
   input  logic [vrt_pkg::EXP_W-1:0] op_b,
   output vrt_pkg::alu_res_type      res
);
   import vrt_pkg::*;

   logic [EXP_W:0] sub;

   // borrow of a - b marks a below b
   assign sub      = {1'b0, op_a} - {1'b0, op_b};
   assign res.lt   = sub[EXP_W];
   assign res.eq   = (sub[EXP_W-1:0] == '0);
   assign res.diff = sub[EXP_W-1:0];

endmodule

@@ dv/record_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_table_checker
// Watches the command and result channels of the versioned record table,
// keeps a shadow copy of the table to predict each result, and compares
// every result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module record_table_checker (
   input  logic clock,
   input  logic reset,
   vrt_req_if   req_mon,
   vrt_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   compared
);
   import vrt_pkg::*;

   typedef struct packed {
      logic              found;
      logic              updated;
      logic              conflict;
      logic              table_full;
      logic [SEQ_W-1:0]  seq;
      logic [TIME_W-1:0] remaining;
      logic [DATA_W-1:0] value;
   } outcome_type;

   // shadow copy of the table
   bit               in_use     [SLOTS];
   logic [KEY_W-1:0] shadow_key [SLOTS];
   logic [LEN_W-1:0] shadow_klen[SLOTS];
   logic [SEQ_W-1:0] shadow_seq [SLOTS];
   logic [VAL_W-1:0] shadow_val [SLOTS];
   logic [LEN_W-1:0] shadow_vlen[SLOTS];
   logic [EXP_W-1:0] shadow_exp [SLOTS];

   outcome_type pending_outcomes[$];
   int          errors  = 0;
   int          checked = 0;

   // ones in the first n bytes
   function automatic logic [DATA_W-1:0] low_bytes(input logic [LEN_W-1:0] n);
      if (n >= LEN_W'(8)) return '1;
      return (DATA_W'(1) << (8 * int'(n))) - DATA_W'(1);
   endfunction

   // expiry minus now, clipped to the 32-bit range
   function automatic logic [TIME_W-1:0] time_left(input logic [EXP_W-1:0] expiry,
                                                   input logic [TIME_W-1:0] now);
      logic [EXP_W-1:0] d;
      if (expiry <= EXP_W'(now)) return '0;
      d = expiry - EXP_W'(now);
      return d[EXP_W-1] ? '1 : d[TIME_W-1:0];
   endfunction

   // apply one command to the shadow table and return its result
   function automatic outcome_type table_outcome(
      input cmd_type           cmd,
      input logic [KEY_W-1:0]  key_in,
      input logic [LEN_W-1:0]  klen_in,
      input logic [SEQ_W-1:0]  seq,
      input logic [VAL_W-1:0]  val_in,
      input logic [LEN_W-1:0]  vlen_in,
      input logic [TIME_W-1:0] life,
      input logic [TIME_W-1:0] now);
      outcome_type      o;
      logic [LEN_W-1:0] klen;
      logic [LEN_W-1:0] vlen;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      logic [EXP_W-1:0] new_exp;
      logic [SEQ_W-1:0] seq_gap;
      int               hit;
      int               free;
      o       = '0;
      klen    = (klen_in > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : klen_in;
      vlen    = (vlen_in > LEN_W'(VALUE_BYTES)) ? LEN_W'(VALUE_BYTES) : vlen_in;
      key     = key_in & low_bytes(klen);
      val     = val_in & low_bytes(vlen);
      new_exp = EXP_W'(now) + EXP_W'(life);
      hit     = -1;
      free    = -1;
      // lowest matching slot and lowest free slot
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!in_use[i]) free = i;
         else if (shadow_klen[i] == klen && shadow_key[i] == key) hit = i;
      end

      if (hit < 0) begin
         // unknown key: only an update does anything
         if (cmd != CMD_UPDATE) return o;
         if (free < 0) begin
            o.table_full = 1'b1;
            return o;
         end
         hit              = free;
         in_use[hit]      = 1'b1;
         shadow_key[hit]  = key;
         shadow_klen[hit] = klen;
         shadow_seq[hit]  = seq;
         shadow_val[hit]  = val;
         shadow_vlen[hit] = vlen;
         shadow_exp[hit]  = new_exp;
         o.updated        = 1'b1;
      end else begin
         o.found = 1'b1;
         case (cmd)
            CMD_UPDATE: begin
               if (shadow_seq[hit] == seq) begin
                  if (shadow_vlen[hit] == vlen && shadow_val[hit] == val) begin
                     // refresh: expiry only moves later
                     if (shadow_exp[hit] < new_exp) begin
                        shadow_exp[hit] = new_exp;
                        o.updated       = 1'b1;
                     end
                  end else begin
                     // conflict: the later expiry wins, ties go to the newcomer
                     o.conflict = 1'b1;
                     if (!(shadow_exp[hit] > new_exp)) begin
                        shadow_val[hit]  = val;
                        shadow_vlen[hit] = vlen;
                        shadow_exp[hit]  = new_exp;
                        o.updated        = 1'b1;
                     end
                  end
               end else begin
                  // wraparound compare, a half-range gap counts as stored newer
                  seq_gap = seq - shadow_seq[hit];
                  if ((seq_gap & SEQ_HALF) == '0) begin
                     shadow_seq[hit]  = seq;
                     shadow_val[hit]  = val;
                     shadow_vlen[hit] = vlen;
                     shadow_exp[hit]  = new_exp;
                     o.updated        = 1'b1;
                  end
               end
            end
            CMD_EXTEND: begin
               if (shadow_exp[hit] < EXP_W'(now)) shadow_seq[hit] = shadow_seq[hit] + 1'b1;
               if (shadow_exp[hit] < new_exp) begin
                  shadow_exp[hit] = new_exp;
                  o.updated       = 1'b1;
               end
            end
            CMD_FLUSH: begin
               in_use[hit] = 1'b0;
               return o;
            end
            default: ;
         endcase
      end

      o.seq       = shadow_seq[hit];
      o.remaining = time_left(shadow_exp[hit], now);
      o.value     = shadow_val[hit];
      return o;
   endfunction

   // compare one result field
   task automatic note_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // watch both channels, results first, then new commands
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) in_use[i] = 1'b0;
         pending_outcomes.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            checked++;
            if (pending_outcomes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t result transfer with no command outstanding", $realtime);
            end else begin
               want = pending_outcomes.pop_front();
               note_field("found", DATA_W'(want.found), DATA_W'(rsp_mon.found));
               note_field("updated", DATA_W'(want.updated), DATA_W'(rsp_mon.updated));
               note_field("conflict", DATA_W'(want.conflict), DATA_W'(rsp_mon.conflict));
               note_field("table_full", DATA_W'(want.table_full),
                          DATA_W'(rsp_mon.table_full));
               note_field("stored_sequence", DATA_W'(want.seq),
                          DATA_W'(rsp_mon.stored_sequence));
               note_field("remaining_seconds", DATA_W'(want.remaining),
                          DATA_W'(rsp_mon.remaining_seconds));
               note_field("stored_value", want.value, rsp_mon.stored_value);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            pending_outcomes.push_back(table_outcome(
               cmd_type'(req_mon.command), req_mon.record_key, req_mon.key_length,
               req_mon.sequence_req, req_mon.record_value, req_mon.value_length,
               req_mon.lifetime, req_mon.now_seconds));
      end
      fail_count <= errors;
      pending    <= pending_outcomes.size();
      compared   <= checked;
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the versioned record table with a directed opening and then random
// commands over a small key pool, under four flow-control phases; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import vrt_pkg::*;

   localparam int POOL        = 24;
   localparam int PHASE_ITEMS = 135;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vrt_req_if req_bus ();
   vrt_rsp_if rsp_bus ();

   int fail_count;
   int pending;
   int compared;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int sent        = 0;

   // key pool with the sequence and value last used per key
   logic [KEY_W-1:0] pool_key [POOL];
   logic [LEN_W-1:0] pool_klen[POOL];
   logic [SEQ_W-1:0] pool_seq [POOL];
   logic [VAL_W-1:0] pool_val [POOL];
   logic [LEN_W-1:0] pool_vlen[POOL];
   logic [TIME_W-1:0] now_t = 32'd2000;

   versioned_record_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   record_table_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .compared   (compared)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ones in the first n bytes
   function automatic logic [DATA_W-1:0] byte_keep(input logic [LEN_W-1:0] n);
      if (n >= LEN_W'(8)) return '1;
      return (DATA_W'(1) << (8 * int'(n))) - DATA_W'(1);
   endfunction

   // one command transfer, with random idle cycles ahead of it
   task automatic send(input cmd_type cmd, input logic [KEY_W-1:0] key,
                       input logic [LEN_W-1:0] klen, input logic [SEQ_W-1:0] seq,
                       input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] vlen,
                       input logic [TIME_W-1:0] life, input logic [TIME_W-1:0] now);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.record_key   <= key;
      req_bus.key_length   <= klen;
      req_bus.sequence_req <= seq;
      req_bus.record_value <= val;
      req_bus.value_length <= vlen;
      req_bus.lifetime     <= life;
      req_bus.now_seconds  <= now;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent++;
   endtask

   // hold off new commands until every result is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // one random command, mostly on pooled keys so records get revisited
   task automatic random_command();
      int               r;
      int               p;
      cmd_type          cmd;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] klen;
      logic [SEQ_W-1:0] seq;
      logic [VAL_W-1:0] val;
      logic [LEN_W-1:0] vlen;
      logic [TIME_W-1:0] life;
      r = $urandom_range(99);
      p = $urandom_range(POOL - 1);
      cmd = (r < 50) ? CMD_UPDATE : (r < 70) ? CMD_LOOKUP : (r < 85) ? CMD_EXTEND : CMD_FLUSH;

      // time mostly creeps forward, now and then jumps anywhere
      now_t = now_t + 32'($urandom_range(12));
      if ($urandom_range(99) < 2) now_t = $urandom;

      // pooled key, overlong length and junk above the valid bytes
      klen = pool_klen[p];
      if (klen == LEN_W'(8) && $urandom_range(1)) klen = LEN_W'($urandom_range(8, 15));
      key = pool_key[p] | ({$urandom, $urandom} & ~byte_keep(klen));
      if (cmd != CMD_UPDATE && $urandom_range(9) == 0) begin
         // noise on a key that is almost surely unknown
         klen = LEN_W'($urandom_range(15));
         key  = {$urandom, $urandom};
      end

      case ($urandom_range(9))
         0, 1, 2, 3: seq = pool_seq[p];
         4, 5:       seq = pool_seq[p] + 16'd1;
         6:          seq = pool_seq[p] - 16'd1;
         7:          seq = pool_seq[p] + SEQ_HALF;
         8:          seq = pool_seq[p] + 16'($urandom_range(1, 16'h7FFF));
         default:    seq = 16'($urandom);
      endcase
      if (cmd == CMD_UPDATE) pool_seq[p] = seq;

      // value mostly repeats so refreshes and equal-value matches occur
      if ($urandom_range(3) == 0) pool_val[p] = {$urandom, $urandom};
      if ($urandom_range(7) == 0) pool_vlen[p] = LEN_W'($urandom_range(15));
      vlen = pool_vlen[p];
      val  = (pool_val[p] & byte_keep(vlen)) | ({$urandom, $urandom} & ~byte_keep(vlen));

      r = $urandom_range(99);
      if (r < 60)      life = $urandom_range(60);
      else if (r < 80) life = $urandom_range(2000);
      else if (r < 90) life = '0;
      else if (r < 95) life = '1;
      else             life = $urandom;

      send(cmd, key, klen, seq, val, vlen, life, now_t);
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_UPDATE;
      req_bus.record_key   = '0;
      req_bus.key_length   = '0;
      req_bus.sequence_req = '0;
      req_bus.record_value = '0;
      req_bus.value_length = '0;
      req_bus.lifetime     = '0;
      req_bus.now_seconds  = '0;
      rsp_bus.ready        = 1'b0;

      // key pool: empty key, all-ones key, then random keys
      for (int i = 0; i < POOL; i++) begin
         pool_klen[i] = LEN_W'($urandom_range(1, 8));
         pool_key[i]  = {$urandom, $urandom} & byte_keep(pool_klen[i]);
         pool_seq[i]  = 16'($urandom);
         pool_val[i]  = {$urandom, $urandom};
         pool_vlen[i] = LEN_W'($urandom_range(8));
      end
      pool_klen[0] = '0;
      pool_key[0]  = '0;
      pool_klen[1] = LEN_W'(8);
      pool_key[1]  = '1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown key on each non-update command
      send(CMD_LOOKUP, '1, 4'd8, 16'h0, '0, 4'd0, 32'd0, 32'd0);
      send(CMD_EXTEND, '1, 4'd8, 16'h0, '0, 4'd0, 32'd5, 32'd0);
      send(CMD_FLUSH,  '1, 4'd8, 16'h0, '0, 4'd0, 32'd0, 32'd0);
      // all-ones record with the latest possible expiry, remaining time clipped
      send(CMD_UPDATE, '1, 4'd8, 16'hFFFF, '1, 4'd8, '1, '1);
      send(CMD_LOOKUP, '1, 4'd8, 16'h0, '0, 4'd0, 32'd0, 32'd0);
      // same number and value, earlier expiry: no change
      send(CMD_UPDATE, '1, 4'd8, 16'hFFFF, '1, 4'd8, 32'd1, 32'd0);
      // conflict lost to the later stored expiry
      send(CMD_UPDATE, '1, 4'd8, 16'hFFFF, '0, 4'd0, 32'd1, 32'd0);
      // half-range gap counts as stored newer
      send(CMD_UPDATE, '1, 4'd8, 16'h7FFF, 64'h55, 4'd1, 32'd1, 32'd0);
      // newer number across the wrap replaces the record
      send(CMD_UPDATE, '1, 4'd8, 16'h0000, 64'h1234, 4'd2, 32'd100, 32'd50);
      // empty key, junk key bits ignored
      send(CMD_UPDATE, 64'hDEAD, 4'd0, 16'd5, 64'h11, 4'd1, 32'd10, 32'd100);
      // conflict with equal expiry goes to the newcomer
      send(CMD_UPDATE, '0, 4'd0, 16'd5, 64'h22, 4'd1, 32'd10, 32'd100);
      send(CMD_UPDATE, '0, 4'd0, 16'd5, 64'h33, 4'd1, 32'd5, 32'd100);
      // refresh pushes expiry later
      send(CMD_UPDATE, '0, 4'd0, 16'd5, 64'hFF22, 4'd1, 32'd20, 32'd100);
      // older incoming number is dropped
      send(CMD_UPDATE, '0, 4'd0, 16'd4, 64'h44, 4'd1, 32'd90, 32'd100);
      // extend an expired record bumps its number
      send(CMD_EXTEND, '0, 4'd0, 16'd0, '0, 4'd0, 32'd0, 32'd500);
      send(CMD_EXTEND, '0, 4'd0, 16'd0, '0, 4'd0, 32'd0, 32'd500);
      send(CMD_LOOKUP, '0, 4'd0, 16'd0, '0, 4'd0, 32'd0, 32'd1000);
      // overlong key and value lengths
      send(CMD_UPDATE, 64'h0102030405060708, 4'd15, 16'd9, '1, 4'd12, 32'd30, 32'd1000);
      send(CMD_LOOKUP, 64'h0102030405060708, 4'd8, 16'd0, '0, 4'd0, 32'd0, 32'd1000);
      // flush twice: found, then unknown
      send(CMD_FLUSH,  '0, 4'd0, 16'd0, '0, 4'd0, 32'd0, 32'd1000);
      send(CMD_FLUSH,  '0, 4'd0, 16'd0, '0, 4'd0, 32'd0, 32'd1000);
      send(CMD_LOOKUP, '1, 4'd8, 16'd0, '0, 4'd0, 32'd0, '1);
      drain();

      // random phases: free flow, sender idle, receiver stall, both light
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 66 : (phase == 3) ? 9 : 0;
         stall_pct <= (phase == 2) ? 66 : (phase == 3) ? 9 : 0;
         repeat (PHASE_ITEMS) random_command();
         drain();
      end

      stall_pct <= 0;
      repeat (30) @(posedge clock);

      $display("sent %0d commands (directed cases, then pooled keys under four flow phases)",
               sent);
      $display("compared %0d results, %0d field mismatches", compared, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
